### src/btpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpa_pkg
// Shared types, constants and helpers of the buddy tree page allocator.
// ----------------------------------------------------------------------------
package btpa_pkg;

	localparam int TREE_LEVELS = 18;
	localparam int PAGE_SHIFT  = 12;
	localparam int PAGES_W     = 21;
	localparam int ADDR_W      = 32;
	localparam int CMD_W       = 2;

	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

	typedef enum logic [1:0] {
		NS_FREE  = 2'd0,
		NS_PART  = 2'd1,
		NS_ALLOC = 2'd2,
		NS_FULL  = 2'd3
	} node_st_t;

	typedef enum logic [1:0] {
		RS_ROOT,
		RS_SELF,
		RS_LEFT,
		RS_RIGHT
	} rd_sel_t;

	typedef enum logic [2:0] {
		MV_HOLD,
		MV_LEFT,
		MV_RIGHT,
		MV_ADDR,
		MV_UP
	} mv_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_A_ROOT,
		ST_A_ENTER,
		ST_A_TGT,
		ST_A_C0,
		ST_A_C1,
		ST_F_RD,
		ST_F_CHK,
		ST_M_RD,
		ST_M_CHK,
		ST_UP,
		ST_RD_L,
		ST_RD_R,
		ST_RD_P,
		ST_A_SET,
		ST_M_SET,
		ST_F_FIX,
		ST_DONE
	} ctl_state_t;

	typedef struct packed {
		rd_sel_t  rd_sel;
		logic     we;
		node_st_t wstate;
		logic     clr_step;
		logic     load;
		mv_t      mv;
		logic     cap_left;
		logic     cap_right;
		logic     set_ok;
		logic     set_grant;
		logic     set_freed;
		logic     load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0]       rdata;
		logic [1:0]       left_st;
		logic [1:0]       right_st;
		logic [CMD_W-1:0] cmd;
		logic             pc_zero;
		logic             cap_ok;
		logic             at_root;
		logic             at_leaf;
		logic             at_cap;
		logic             is_target;
		logic             eq_base;
		logic             k;
		logic             ok;
		logic             out_free;
		logic             clr_last;
	} dp_sts_t;

	function automatic logic usable(input logic [1:0] s);
		return (s == NS_FREE) || (s == NS_PART);
	endfunction

endpackage

### src/btpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpa_req_if
// Request channel: command, page count and byte address.
// ----------------------------------------------------------------------------
interface btpa_req_if;
	logic                            valid;
	logic                            ready;
	logic [btpa_pkg::CMD_W-1:0]      cmd;
	logic [btpa_pkg::PAGES_W-1:0]    page_count;
	logic [btpa_pkg::ADDR_W-1:0]     byte_address;

	modport source (output valid, output cmd, output page_count, output byte_address,
		input ready);
	modport sink (input valid, input cmd, input page_count, input byte_address,
		output ready);
endinterface

### src/btpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpa_rsp_if
// Response channel: status, granted address and freed page count.
// ----------------------------------------------------------------------------
interface btpa_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            status;
	logic [btpa_pkg::ADDR_W-1:0]     granted_address;
	logic [btpa_pkg::PAGES_W-1:0]    freed_pages;

	modport source (output valid, output status, output granted_address,
		output freed_pages, input ready);
	modport sink (input valid, input status, input granted_address,
		input freed_pages, output ready);
endinterface

### src/btpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btpa_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/btpa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpa_dp
// Datapath: node cursor, address math, node store and result register.
// ----------------------------------------------------------------------------
module btpa_dp #(
	parameter int TREE_LEVELS = btpa_pkg::TREE_LEVELS,
	parameter int PAGE_SHIFT  = btpa_pkg::PAGE_SHIFT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  btpa_pkg::dp_cmd_t              cmd,
	output btpa_pkg::dp_sts_t              sts,
	input  logic [btpa_pkg::CMD_W-1:0]     req_cmd,
	input  logic [btpa_pkg::PAGES_W-1:0]   req_page_count,
	input  logic [btpa_pkg::ADDR_W-1:0]    req_byte_address,
	input  logic                           rsp_ready,
	output logic                           rsp_valid,
	output logic                           rsp_status,
	output logic [btpa_pkg::ADDR_W-1:0]    rsp_granted_address,
	output logic [btpa_pkg::PAGES_W-1:0]   rsp_freed_pages
);

	localparam int IW    = TREE_LEVELS + 1;
	localparam int LW    = $clog2(TREE_LEVELS + 1);
	localparam int NODES = 1 << IW;
	localparam int PW    = btpa_pkg::PAGES_W;
	localparam int AW    = btpa_pkg::ADDR_W;
	localparam int BW    = $clog2(btpa_pkg::PAGES_W + 1);
	localparam int SW    = 7;

	logic [IW-1:0]                  idx_q;
	logic [LW-1:0]                  d_q;
	logic                           k_q;
	logic [btpa_pkg::CMD_W-1:0]     cmd_q;
	logic [PW-1:0]                  pc_q;
	logic [AW-1:0]                  addr_q;
	logic [LW-1:0]                  cap_q;
	logic                           cap_ok_q;
	logic                           ok_q;
	logic [AW-1:0]                  grant_q;
	logic [PW-1:0]                  freed_q;
	logic [1:0]                     left_q;
	logic [1:0]                     right_q;
	logic [IW-1:0]                  clr_q;
	logic                           out_valid_q;
	logic                           out_status_q;
	logic [AW-1:0]                  out_grant_q;
	logic [PW-1:0]                  out_freed_q;

	logic [IW-1:0]                  raddr;
	logic [IW-1:0]                  waddr;
	logic [1:0]                     wdata;
	logic                           we;
	logic [1:0]                     rdata;

	logic [BW-1:0]                  bits;
	logic                           pow2;
	logic signed [7:0]              cap_s;

	logic [LW-1:0]                  sh_lvl;
	logic [SW-1:0]                  bsh;
	logic [IW-1:0]                  off;
	logic [63:0]                    base64;
	logic [63:0]                    half64;
	logic [AW-1:0]                  base;
	logic [AW-1:0]                  mid;
	logic [PW:0]                    thr;
	logic [PW-1:0]                  pages;
	logic                           lt_mid;
	logic                           dn_bit;

	// node store
	always_comb begin
		unique case (cmd.rd_sel)
			btpa_pkg::RS_ROOT:  raddr = IW'(1);
			btpa_pkg::RS_SELF:  raddr = idx_q;
			btpa_pkg::RS_LEFT:  raddr = {idx_q[IW-2:0], 1'b0};
			btpa_pkg::RS_RIGHT: raddr = {idx_q[IW-2:0], 1'b1};
			default:            raddr = idx_q;
		endcase
	end

	assign we    = cmd.we | cmd.clr_step;
	assign waddr = cmd.clr_step ? clr_q : idx_q;
	assign wdata = cmd.clr_step ? btpa_pkg::NS_FREE : cmd.wstate;

	btpa_ram #(
		.WIDTH (2),
		.DEPTH (NODES)
	) u_node_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// mark level from the bit length of the page count
	always_comb begin
		bits = '0;
		for (int i = 0; i < PW; i++) begin
			if (req_page_count[i]) begin
				bits = BW'(i + 1);
			end
		end
		pow2 = ((req_page_count & (req_page_count - PW'(1))) == '0);
		if (bits <= BW'(2)) begin
			cap_s = 8'(TREE_LEVELS);
		end else begin
			cap_s = $signed(8'(TREE_LEVELS + 2)) - $signed(8'(bits))
				+ $signed({7'b0, pow2});
		end
	end

	// node geometry at the cursor
	assign sh_lvl = LW'(TREE_LEVELS) - d_q;
	assign bsh    = SW'(sh_lvl) + SW'(2 + PAGE_SHIFT);
	assign off    = idx_q & ((IW'(1) << d_q) - IW'(1));
	assign base64 = 64'(off) << bsh;
	assign half64 = 64'(1) << (bsh - SW'(1));
	assign base   = base64[AW-1:0];
	assign mid    = base + half64[AW-1:0];
	assign thr    = (PW+1)'(2) << sh_lvl;
	assign pages  = PW'(4) << sh_lvl;
	assign lt_mid = addr_q < mid;
	assign dn_bit = (cmd.mv == btpa_pkg::MV_RIGHT)
		|| ((cmd.mv == btpa_pkg::MV_ADDR) && !lt_mid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= IW'(1);
			d_q         <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + IW'(1);
			end
			if (cmd.load) begin
				idx_q <= IW'(1);
				d_q   <= '0;
			end else begin
				case (cmd.mv)
					btpa_pkg::MV_LEFT, btpa_pkg::MV_RIGHT, btpa_pkg::MV_ADDR: begin
						idx_q <= {idx_q[IW-2:0], dn_bit};
						d_q   <= d_q + LW'(1);
					end
					btpa_pkg::MV_UP: begin
						idx_q <= idx_q >> 1;
						d_q   <= d_q - LW'(1);
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q    <= req_cmd;
			pc_q     <= req_page_count;
			addr_q   <= req_byte_address;
			cap_q    <= cap_s[LW-1:0];
			cap_ok_q <= !cap_s[7];
			ok_q     <= 1'b0;
			grant_q  <= '0;
			freed_q  <= '0;
		end else begin
			if (cmd.set_ok) begin
				ok_q <= 1'b1;
			end
			if (cmd.set_grant) begin
				grant_q <= base;
			end
			if (cmd.set_freed) begin
				freed_q <= pages;
			end
		end
		if (cmd.mv == btpa_pkg::MV_UP) begin
			k_q <= idx_q[0];
		end
		if (cmd.cap_left) begin
			left_q <= rdata;
		end
		if (cmd.cap_right) begin
			right_q <= rdata;
		end
		if (cmd.load_out) begin
			out_status_q <= !ok_q;
			out_grant_q  <= ok_q ? grant_q : '0;
			out_freed_q  <= freed_q;
		end
	end

	assign sts.rdata     = rdata;
	assign sts.left_st   = left_q;
	assign sts.right_st  = right_q;
	assign sts.cmd       = cmd_q;
	assign sts.pc_zero   = (pc_q == '0);
	assign sts.cap_ok    = cap_ok_q;
	assign sts.at_root   = (d_q == '0);
	assign sts.at_leaf   = (d_q == LW'(TREE_LEVELS));
	assign sts.at_cap    = (d_q == cap_q);
	assign sts.is_target = (d_q == LW'(TREE_LEVELS)) || ({1'b0, pc_q} > thr);
	assign sts.eq_base   = (addr_q == base);
	assign sts.k         = k_q;
	assign sts.ok        = ok_q;
	assign sts.out_free  = !out_valid_q || rsp_ready;
	assign sts.clr_last  = &clr_q;

	assign rsp_valid           = out_valid_q;
	assign rsp_status          = out_status_q;
	assign rsp_granted_address = out_grant_q;
	assign rsp_freed_pages     = out_freed_q;

	// the cursor index always has its leading one at the current level
	a_idx_level: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q >> d_q) == IW'(1))
		else $error("node index does not match level");

	a_no_descent_below_leaf: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mv == btpa_pkg::MV_LEFT || cmd.mv == btpa_pkg::MV_RIGHT
			|| cmd.mv == btpa_pkg::MV_ADDR) |-> d_q != LW'(TREE_LEVELS))
		else $error("descent below leaf level");

	a_no_ascent_above_root: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mv == btpa_pkg::MV_UP) |-> d_q != '0)
		else $error("ascent above root");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || rsp_ready))
		else $error("result overwritten before taken");

endmodule

### src/btpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpa_ctrl
// Controller: sequences the tree walk for allocate, free and mark.
// ----------------------------------------------------------------------------
module btpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  btpa_pkg::dp_sts_t  sts,
	output btpa_pkg::dp_cmd_t  cmd
);

	btpa_pkg::ctl_state_t state_q;
	btpa_pkg::ctl_state_t state_d;

	logic both_unusable;

	assign both_unusable = !btpa_pkg::usable(sts.left_st) && !btpa_pkg::usable(sts.rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btpa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btpa_pkg::ST_CLEAR: begin
				if (sts.clr_last) begin
					state_d = btpa_pkg::ST_IDLE;
				end
			end
			btpa_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = btpa_pkg::ST_DISPATCH;
				end
			end
			btpa_pkg::ST_DISPATCH: begin
				if (sts.cmd == btpa_pkg::CMD_ALLOC) begin
					state_d = sts.pc_zero ? btpa_pkg::ST_DONE : btpa_pkg::ST_A_ROOT;
				end else if (sts.cmd == btpa_pkg::CMD_FREE) begin
					state_d = btpa_pkg::ST_F_RD;
				end else if (sts.cmd == btpa_pkg::CMD_MARK && !sts.pc_zero && sts.cap_ok) begin
					state_d = btpa_pkg::ST_M_RD;
				end else begin
					state_d = btpa_pkg::ST_DONE;
				end
			end
			btpa_pkg::ST_A_ROOT: begin
				state_d = btpa_pkg::usable(sts.rdata) ? btpa_pkg::ST_A_ENTER : btpa_pkg::ST_DONE;
			end
			btpa_pkg::ST_A_ENTER: begin
				state_d = sts.is_target ? btpa_pkg::ST_A_TGT : btpa_pkg::ST_A_C0;
			end
			btpa_pkg::ST_A_TGT: state_d = btpa_pkg::ST_UP;
			btpa_pkg::ST_A_C0: begin
				state_d = btpa_pkg::usable(sts.rdata) ? btpa_pkg::ST_A_ENTER : btpa_pkg::ST_A_C1;
			end
			btpa_pkg::ST_A_C1: begin
				state_d = btpa_pkg::usable(sts.rdata) ? btpa_pkg::ST_A_ENTER : btpa_pkg::ST_UP;
			end
			btpa_pkg::ST_F_RD: state_d = btpa_pkg::ST_F_CHK;
			btpa_pkg::ST_F_CHK: begin
				if (sts.eq_base && sts.rdata == btpa_pkg::NS_ALLOC) begin
					state_d = btpa_pkg::ST_UP;
				end else if (sts.at_leaf) begin
					state_d = btpa_pkg::ST_DONE;
				end else begin
					state_d = btpa_pkg::ST_F_RD;
				end
			end
			btpa_pkg::ST_M_RD: state_d = btpa_pkg::ST_M_CHK;
			btpa_pkg::ST_M_CHK: begin
				if (sts.at_cap) begin
					state_d = (sts.eq_base && sts.rdata == btpa_pkg::NS_FREE)
						? btpa_pkg::ST_UP : btpa_pkg::ST_DONE;
				end else if (sts.rdata == btpa_pkg::NS_ALLOC) begin
					state_d = btpa_pkg::ST_DONE;
				end else begin
					state_d = btpa_pkg::ST_M_RD;
				end
			end
			btpa_pkg::ST_UP: begin
				state_d = sts.at_root ? btpa_pkg::ST_DONE : btpa_pkg::ST_RD_L;
			end
			btpa_pkg::ST_RD_L: state_d = btpa_pkg::ST_RD_R;
			btpa_pkg::ST_RD_R: begin
				if (sts.cmd == btpa_pkg::CMD_FREE) begin
					state_d = btpa_pkg::ST_RD_P;
				end else if (sts.cmd == btpa_pkg::CMD_ALLOC) begin
					state_d = btpa_pkg::ST_A_SET;
				end else begin
					state_d = btpa_pkg::ST_M_SET;
				end
			end
			btpa_pkg::ST_RD_P: state_d = btpa_pkg::ST_F_FIX;
			btpa_pkg::ST_A_SET: begin
				// left subtree failed: try the right sibling if it is usable
				if (!both_unusable && !sts.ok && !sts.k && btpa_pkg::usable(sts.rdata)) begin
					state_d = btpa_pkg::ST_A_ENTER;
				end else begin
					state_d = btpa_pkg::ST_UP;
				end
			end
			btpa_pkg::ST_M_SET: state_d = btpa_pkg::ST_UP;
			btpa_pkg::ST_F_FIX: state_d = btpa_pkg::ST_UP;
			btpa_pkg::ST_DONE: begin
				if (sts.out_free) begin
					state_d = btpa_pkg::ST_IDLE;
				end
			end
			default: state_d = btpa_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd           = '0;
		cmd.rd_sel    = btpa_pkg::RS_SELF;
		cmd.mv        = btpa_pkg::MV_HOLD;
		cmd.wstate    = btpa_pkg::NS_FREE;
		req_ready     = 1'b0;
		unique case (state_q)
			btpa_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
			btpa_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.load  = req_valid;
			end
			btpa_pkg::ST_DISPATCH: cmd.rd_sel = btpa_pkg::RS_ROOT;
			btpa_pkg::ST_A_ENTER: begin
				cmd.rd_sel = sts.is_target ? btpa_pkg::RS_SELF : btpa_pkg::RS_LEFT;
			end
			btpa_pkg::ST_A_TGT: begin
				if (sts.rdata != btpa_pkg::NS_PART) begin
					cmd.we        = 1'b1;
					cmd.wstate    = btpa_pkg::NS_ALLOC;
					cmd.set_grant = 1'b1;
					cmd.set_ok    = 1'b1;
				end
			end
			btpa_pkg::ST_A_C0: begin
				if (btpa_pkg::usable(sts.rdata)) begin
					cmd.mv = btpa_pkg::MV_LEFT;
				end else begin
					cmd.rd_sel = btpa_pkg::RS_RIGHT;
				end
			end
			btpa_pkg::ST_A_C1: begin
				if (btpa_pkg::usable(sts.rdata)) begin
					cmd.mv = btpa_pkg::MV_RIGHT;
				end
			end
			btpa_pkg::ST_F_CHK: begin
				if (sts.eq_base && sts.rdata == btpa_pkg::NS_ALLOC) begin
					cmd.we        = 1'b1;
					cmd.wstate    = btpa_pkg::NS_FREE;
					cmd.set_freed = 1'b1;
					cmd.set_ok    = 1'b1;
				end else if (!sts.at_leaf) begin
					cmd.mv = btpa_pkg::MV_ADDR;
				end
			end
			btpa_pkg::ST_M_CHK: begin
				if (sts.at_cap) begin
					if (sts.eq_base && sts.rdata == btpa_pkg::NS_FREE) begin
						cmd.we     = 1'b1;
						cmd.wstate = btpa_pkg::NS_ALLOC;
						cmd.set_ok = 1'b1;
					end
				end else if (sts.rdata != btpa_pkg::NS_ALLOC) begin
					cmd.mv = btpa_pkg::MV_ADDR;
				end
			end
			btpa_pkg::ST_UP: begin
				if (!sts.at_root) begin
					cmd.mv = btpa_pkg::MV_UP;
				end
			end
			btpa_pkg::ST_RD_L: cmd.rd_sel = btpa_pkg::RS_LEFT;
			btpa_pkg::ST_RD_R: begin
				cmd.rd_sel   = btpa_pkg::RS_RIGHT;
				cmd.cap_left = 1'b1;
			end
			btpa_pkg::ST_RD_P: begin
				cmd.rd_sel    = btpa_pkg::RS_SELF;
				cmd.cap_right = 1'b1;
			end
			btpa_pkg::ST_A_SET: begin
				if (both_unusable) begin
					cmd.we     = 1'b1;
					cmd.wstate = btpa_pkg::NS_FULL;
				end else if (sts.ok) begin
					cmd.we     = 1'b1;
					cmd.wstate = btpa_pkg::NS_PART;
				end else if (!sts.k && btpa_pkg::usable(sts.rdata)) begin
					cmd.mv = btpa_pkg::MV_RIGHT;
				end
			end
			btpa_pkg::ST_M_SET: begin
				cmd.we     = 1'b1;
				cmd.wstate = both_unusable ? btpa_pkg::NS_FULL : btpa_pkg::NS_PART;
			end
			btpa_pkg::ST_F_FIX: begin
				// merge buddies, or reopen a full parent
				if (sts.left_st == btpa_pkg::NS_FREE && sts.right_st == btpa_pkg::NS_FREE) begin
					cmd.we     = 1'b1;
					cmd.wstate = btpa_pkg::NS_FREE;
				end else if (sts.rdata == btpa_pkg::NS_FULL) begin
					cmd.we     = 1'b1;
					cmd.wstate = btpa_pkg::NS_PART;
				end
			end
			btpa_pkg::ST_DONE: cmd.load_out = sts.out_free;
			default: begin
			end
		endcase
	end

endmodule

### src/buddy_tree_page_allocator.sv
`timescale 1ns / 1ps
// sequence: allocate descends each level via A_ENTER and A_C0 (A_C1 if the left
//   child is unusable) and climbs through UP, RD_L, RD_R and A_SET, more when it backs
//   out of a subtree; free and mark descend through read and check states and climb
//   through UP, RD_L, RD_R, then RD_P and F_FIX or M_SET; DONE loads each result
// throughput: one item at a time; a new request is taken only in the idle state
// reset: a clearing pass over the whole node store sets every node free, no
//   item is accepted during it
// ----------------------------------------------------------------------------
// buddy_tree_page_allocator
// Binary buddy page allocator with an implicit node tree in RAM.
// ----------------------------------------------------------------------------
module buddy_tree_page_allocator #(
	parameter int TREE_LEVELS = btpa_pkg::TREE_LEVELS,
	parameter int PAGE_SHIFT  = btpa_pkg::PAGE_SHIFT
) (
	input  logic       clk,
	input  logic       arst_n,
	btpa_req_if.sink   req,
	btpa_rsp_if.source rsp
);

	btpa_pkg::dp_cmd_t dp_cmd;
	btpa_pkg::dp_sts_t dp_sts;

	btpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	btpa_dp #(
		.TREE_LEVELS (TREE_LEVELS),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (dp_cmd),
		.sts                 (dp_sts),
		.req_cmd             (req.cmd),
		.req_page_count      (req.page_count),
		.req_byte_address    (req.byte_address),
		.rsp_ready           (rsp.ready),
		.rsp_valid           (rsp.valid),
		.rsp_status          (rsp.status),
		.rsp_granted_address (rsp.granted_address),
		.rsp_freed_pages     (rsp.freed_pages)
	);

endmodule

### tb/buddy_tree_page_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_tree_page_allocator_tb
// Drives allocate, free, reserve and unknown commands into the buddy page allocator.
// A behavioral copy of the node tree predicts every response the stimulus table lacks.
// Responses are compared field by field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module buddy_tree_page_allocator_tb;
	import btpa_pkg::*;

	localparam int          LEVELS     = TREE_LEVELS;
	localparam int          PSHIFT     = PAGE_SHIFT;
	localparam int unsigned NODES      = 1 << (LEVELS + 1);
	localparam int          RAND_ITEMS = 630;
	localparam longint      CYCLE_CAP  = 6000000;

	typedef struct {
		logic              status;
		logic [ADDR_W-1:0] granted;
		logic [PAGES_W-1:0] freed;
	} alloc_rsp_t;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [PAGES_W-1:0] pages;
		logic [ADDR_W-1:0]  addr;
		bit                 typed;
		alloc_rsp_t         want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	btpa_req_if req_if ();
	btpa_rsp_if rsp_if ();

	buddy_tree_page_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	node_st_t    tree_st [NODES];
	alloc_rsp_t  pending_rsp [$];
	logic [ADDR_W-1:0] held_blocks [$];
	int          mismatches = 0;
	longint      cycles = 0;
	bit          no_idle = 0;
	bit          stim_done = 0;

	initial begin
		clk = 1'b0;
		forever begin
			#1 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- tree predictor ----------------
	function automatic bit can_use(int unsigned i);
		node_st_t s;
		s = tree_st[i & (NODES - 1)];
		return (s == NS_FREE) || (s == NS_PART);
	endfunction

	function automatic longint unsigned blk_pages(int d);
		return 64'd4 << (LEVELS - d);
	endfunction

	function automatic longint unsigned blk_base(int unsigned idx, int d);
		longint unsigned off;
		off = idx & ((1 << d) - 1);
		return ((off * blk_pages(d)) << PSHIFT) & 64'hFFFF_FFFF;
	endfunction

	function automatic longint unsigned blk_mid(int unsigned idx, int d);
		return (blk_base(idx, d) + ((blk_pages(d) / 2) << PSHIFT)) & 64'hFFFF_FFFF;
	endfunction

	function automatic void settle(int unsigned idx);
		if (!can_use(2 * idx) && !can_use(2 * idx + 1))
			tree_st[idx] = NS_FULL;
		else
			tree_st[idx] = NS_PART;
	endfunction

	function automatic bit alloc_dfs(longint unsigned pc, int unsigned idx, int d,
		output longint unsigned a);
		bit ok;
		int unsigned c;
		if (d == LEVELS || pc > (64'd2 << (LEVELS - d))) begin
			if (tree_st[idx] == NS_PART)
				return 0;
			tree_st[idx] = NS_ALLOC;
			a = blk_base(idx, d);
			return 1;
		end
		for (int k = 0; k < 2; k++) begin
			c = 2 * idx + k;
			if (!can_use(c))
				continue;
			ok = alloc_dfs(pc, c, d + 1, a);
			if (!can_use(2 * idx) && !can_use(2 * idx + 1)) begin
				tree_st[idx] = NS_FULL;
				return ok;
			end
			if (ok) begin
				tree_st[idx] = NS_PART;
				return 1;
			end
		end
		return 0;
	endfunction

	function automatic longint unsigned free_dfs(longint unsigned a, int unsigned idx, int d);
		longint unsigned got;
		if (d > LEVELS)
			return 0;
		if (a == blk_base(idx, d) && tree_st[idx] == NS_ALLOC) begin
			tree_st[idx] = NS_FREE;
			return blk_pages(d);
		end
		if (a < blk_mid(idx, d))
			got = free_dfs(a, 2 * idx, d + 1);
		else
			got = free_dfs(a, 2 * idx + 1, d + 1);
		if (got != 0) begin
			if (tree_st[2 * idx] == NS_FREE && tree_st[2 * idx + 1] == NS_FREE)
				tree_st[idx] = NS_FREE;
			else if (tree_st[idx] == NS_FULL)
				tree_st[idx] = NS_PART;
		end
		return got;
	endfunction

	function automatic bit mark_dfs(longint unsigned a, int unsigned idx, int d, int lvl);
		bit ok;
		if (d > LEVELS)
			return 0;
		if (d == lvl) begin
			if (a == blk_base(idx, d) && tree_st[idx] == NS_FREE) begin
				tree_st[idx] = NS_ALLOC;
				return 1;
			end
			return 0;
		end
		if (tree_st[idx] == NS_ALLOC)
			return 0;
		if (a < blk_mid(idx, d))
			ok = mark_dfs(a, 2 * idx, d + 1, lvl);
		else
			ok = mark_dfs(a, 2 * idx + 1, d + 1, lvl);
		if (ok)
			settle(idx);
		return ok;
	endfunction

	// level that a reserve of pc pages lands on, may fall outside the tree
	function automatic int mark_level(longint unsigned pc);
		int nbits;
		int lvl;
		nbits = $clog2(pc + 1);
		if (nbits <= 2)
			return LEVELS;
		lvl = LEVELS - nbits + 2;
		if (pc == (64'd1 << (nbits - 1)))
			lvl++;
		return lvl;
	endfunction

	function automatic alloc_rsp_t apply_item(logic [CMD_W-1:0] cmd, logic [PAGES_W-1:0] pages,
		logic [ADDR_W-1:0] addr);
		alloc_rsp_t r;
		longint unsigned a;
		int lvl;
		r.status  = 1'b1;
		r.granted = '0;
		r.freed   = '0;
		a = 0;
		if (cmd == CMD_ALLOC) begin
			if (pages != 0 && can_use(1) && alloc_dfs(pages, 1, 0, a)) begin
				r.status  = 1'b0;
				r.granted = a[ADDR_W-1:0];
			end
		end else if (cmd == CMD_FREE) begin
			a = free_dfs(addr, 1, 0);
			r.freed = a[PAGES_W-1:0];
			if (a != 0)
				r.status = 1'b0;
		end else if (cmd == CMD_MARK && pages != 0) begin
			lvl = mark_level(pages);
			if (lvl >= 0 && lvl <= LEVELS && mark_dfs(addr, 1, 0, lvl))
				r.status = 1'b0;
		end
		return r;
	endfunction

	// ---------------- request side ----------------
	task automatic push_item(logic [CMD_W-1:0] cmd, logic [PAGES_W-1:0] pages,
		logic [ADDR_W-1:0] addr, bit typed, alloc_rsp_t want);
		int gap;
		alloc_rsp_t r;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid        <= 1'b1;
		req_if.cmd          <= cmd;
		req_if.page_count   <= pages;
		req_if.byte_address <= addr;
		do @(posedge clk); while (!req_if.ready);
		r = apply_item(cmd, pages, addr);
		pending_rsp.push_back(typed ? want : r);
		if (r.status == 1'b0 && (cmd == CMD_ALLOC || cmd == CMD_MARK))
			held_blocks.push_back(cmd == CMD_ALLOC ? r.granted : addr);
	endtask

	// ---------------- response side ----------------
	initial begin
		int gap;
		alloc_rsp_t w;
		rsp_if.ready <= 1'b0;
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 15);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
			if (pending_rsp.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: status %0d addr %h pages %0d",
						rsp_if.status, rsp_if.granted_address, rsp_if.freed_pages);
			end else begin
				w = pending_rsp.pop_front();
				if (rsp_if.status !== w.status || rsp_if.granted_address !== w.granted
					|| rsp_if.freed_pages !== w.freed) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							w.status, w.granted, w.freed, rsp_if.status,
							rsp_if.granted_address, rsp_if.freed_pages);
				end
			end
		end
	end

	// ---------------- stimulus ----------------
	function automatic stim_row_t row(logic [CMD_W-1:0] c, logic [PAGES_W-1:0] p,
		logic [ADDR_W-1:0] a, bit typed, logic s, logic [ADDR_W-1:0] g, logic [PAGES_W-1:0] f);
		stim_row_t t;
		t.cmd = c;
		t.pages = p;
		t.addr = a;
		t.typed = typed;
		t.want.status = s;
		t.want.granted = g;
		t.want.freed = f;
		return t;
	endfunction

	initial begin
		stim_row_t rows [$];
		alloc_rsp_t none;
		logic [CMD_W-1:0] c;
		logic [PAGES_W-1:0] p;
		logic [ADDR_W-1:0] a;
		longint unsigned span;
		int pick;
		int lvl;
		int wait_cnt;

		none.status = 1'b1;
		none.granted = '0;
		none.freed = '0;
		foreach (tree_st[i])
			tree_st[i] = NS_FREE;

		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.cmd <= CMD_ALLOC;
		req_if.page_count <= '0;
		req_if.byte_address <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		rows.push_back(row(CMD_ALLOC, 0, 0, 1, 1, 0, 0));                // zero pages
		rows.push_back(row(CMD_ALLOC, 4, 0, 1, 0, 0, 0));
		rows.push_back(row(CMD_ALLOC, 1, 0, 1, 0, 32'h4000, 0));
		rows.push_back(row(CMD_FREE, 0, 0, 1, 0, 0, 4));
		rows.push_back(row(CMD_FREE, 0, 0, 1, 1, 0, 0));                 // nothing to free
		rows.push_back(row(CMD_FREE, 0, 32'h4000, 1, 0, 0, 4));
		rows.push_back(row(CMD_ALLOC, 21'h100000, 0, 1, 0, 0, 0));       // whole pool
		rows.push_back(row(CMD_ALLOC, 4, 0, 1, 1, 0, 0));                // root taken
		rows.push_back(row(CMD_MARK, 4, 0, 1, 1, 0, 0));                 // allocated ancestor
		rows.push_back(row(CMD_FREE, 0, 0, 1, 0, 0, 21'h100000));
		rows.push_back(row(CMD_ALLOC, 21'h1FFFFF, 0, 1, 0, 0, 0));       // larger than pool
		rows.push_back(row(CMD_FREE, 0, 0, 1, 0, 0, 21'h100000));
		rows.push_back(row(CMD_MARK, 21'h100000, 0, 1, 0, 0, 0));
		rows.push_back(row(CMD_FREE, 0, 0, 1, 0, 0, 21'h100000));
		rows.push_back(row(CMD_MARK, 21'h1FFFFF, 0, 1, 1, 0, 0));        // too large to mark
		rows.push_back(row(CMD_MARK, 0, 0, 1, 1, 0, 0));
		rows.push_back(row(2'd3, 21'h1FFFFF, 32'hFFFF_FFFF, 1, 1, 0, 0)); // unknown command
		rows.push_back(row(CMD_MARK, 4, 32'h4000, 0, 0, 0, 0));
		rows.push_back(row(CMD_MARK, 4, 32'h4001, 0, 0, 0, 0));          // misaligned
		rows.push_back(row(CMD_MARK, 8, 32'h8000, 0, 0, 0, 0));
		rows.push_back(row(CMD_ALLOC, 21'h80000, 0, 0, 0, 0, 0));        // half pool
		rows.push_back(row(CMD_ALLOC, 21'h80001, 0, 0, 0, 0, 0));        // root partly used
		rows.push_back(row(CMD_ALLOC, 21'h80000, 0, 0, 0, 0, 0));        // no free half left
		rows.push_back(row(CMD_FREE, 0, 32'hFFFF_C000, 0, 0, 0, 0));
		rows.push_back(row(CMD_FREE, 0, 32'h8000_0000, 0, 0, 0, 0));

		foreach (rows[i])
			push_item(rows[i].cmd, rows[i].pages, rows[i].addr, rows[i].typed, rows[i].want);
		held_blocks.delete();
		push_item(CMD_FREE, 0, 32'h4000, 0, none);
		push_item(CMD_FREE, 0, 32'h8000, 0, none);
		push_item(CMD_FREE, 0, 32'h0, 0, none);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 60 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			p = '0;
			a = '0;
			if (held_blocks.size() > 48 && pick < 45)
				pick = 50;
			if (pick < 45) begin
				c = CMD_ALLOC;
				case ($urandom_range(0, 9))
					0: p = PAGES_W'($urandom_range(0, 21'h1FFFFF));
					1, 2: p = PAGES_W'($urandom_range(65, 65536));
					default: p = PAGES_W'($urandom_range(1, 64));
				endcase
			end else if (pick < 80) begin
				c = CMD_FREE;
				if (held_blocks.size() > 0 && $urandom_range(0, 9) != 0) begin
					pick = $urandom_range(0, held_blocks.size() - 1);
					a = held_blocks[pick];
					held_blocks.delete(pick);
				end else begin
					a = $urandom;
				end
				p = PAGES_W'($urandom_range(0, 21'h1FFFFF));
			end else if (pick < 95) begin
				c = CMD_MARK;
				p = ($urandom_range(0, 7) == 0) ? PAGES_W'($urandom_range(0, 21'h1FFFFF))
					: PAGES_W'($urandom_range(1, 4096));
				lvl = mark_level(p);
				span = (lvl >= 0 && lvl <= LEVELS) ? (blk_pages(lvl) << PSHIFT) : 64'd1;
				a = $urandom;
				if ($urandom_range(0, 3) != 0)
					a = a & ~(span[ADDR_W-1:0] - 1);
				if ($urandom_range(0, 1) == 0)
					a = a & 32'h00FF_FFFF;
			end else begin
				c = ($urandom_range(0, 1) == 0) ? 2'd3 : CMD_W'($urandom_range(0, 3));
				p = PAGES_W'($urandom_range(0, 21'h1FFFFF));
				a = $urandom;
			end
			push_item(c, p, a, 0, none);
		end
		req_if.valid <= 1'b0;
		no_idle = 0;

		wait_cnt = 0;
		while (pending_rsp.size() != 0 && wait_cnt < 200000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (300) @(posedge clk);
		if (mismatches == 0 && pending_rsp.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
